/* rtl/three_axis_bang_bang_motion_controller_top_assert.svh */
// Assertion macros for the motion controller checker.
`ifndef THREE_AXIS_BANG_BANG_MOTION_CONTROLLER_TOP_ASSERT_SVH
`define THREE_AXIS_BANG_BANG_MOTION_CONTROLLER_TOP_ASSERT_SVH
// Implication checked on every clock, off during reset.
`define TABB_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TABB_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* rtl/tabb_pkg.sv */
// Shared types and constants of the motion controller.
package tabb_pkg;
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_HOME   = 3'd1;
  localparam logic [2:0] OP_MOVE   = 3'd2;
  localparam logic [2:0] OP_CANCEL = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;

  localparam logic [1:0] KIND_DRIVE  = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_NACK   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_HOMING = 2'd1;
  localparam logic [1:0] MODE_MOVING = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [1:0] REG_TOL   = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_NOISE = 2'd2;
  localparam logic [1:0] REG_FAULT = 2'd3;

  // Classified tick handed from front to back.
  typedef struct packed {
    logic [2:0]  op;
    logic [71:0] goals;
    logic        goal_ok;
    logic [2:0]  stops;
    logic [2:0]  enc;
  } tick_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  command;
    logic [71:0] pos;
    logic        known;
    logic [4:0]  status;
    logic [2:0]  enable;
    logic [1:0]  dir_a;
    logic [1:0]  dir_b;
    logic [1:0]  dir_c;
    logic        last;
  } res_t;
endpackage

/* rtl/tabb_front.sv */
// Front: accepts ticks, classifies them and queues them for the back end.
module tabb_front import tabb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [71:0] goals_i,
  input  logic        goal_invalid_i,
  input  logic        payload_ok_i,
  input  logic [2:0]  stops_i,
  input  logic [2:0]  enc_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output tick_t       q_head_o
);
  tick_t      mem_q [2];
  logic [1:0] wr_q, rd_q, cnt_q;
  logic       push;
  tick_t      t;

  // Unused codes count as no command.
  always_comb begin
    t.op = (op_i > OP_STATUS) ? OP_NONE : op_i;
    t.goals = goals_i;
    t.goal_ok = payload_ok_i & ~goal_invalid_i;
    t.stops = stops_i;
    t.enc = enc_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i & ~in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o = mem_q[rd_q[0]];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q[0]] <= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (q_pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

/* rtl/tabb_back.sv */
// Back: runs one tick through its states and takes no new tick until it is done; results wait while the output stalls.
module tabb_back import tabb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  tick_t       tick_i,
  input  logic [15:0] tol_i,
  input  logic [15:0] step_i,
  input  logic [7:0]  noise_i,
  input  logic        fault_i,
  output logic        res_valid_o,
  input  logic        res_take_i,
  output res_t        res_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMD  = 3'd1;
  localparam logic [2:0] ST_CST  = 3'd2;
  localparam logic [2:0] ST_DRV  = 3'd3;
  localparam logic [2:0] ST_ENC  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [1:0]  mode_q, mode_d;
  logic [23:0] pos_q [3];
  logic [23:0] pos_d [3];
  logic        known_q, known_d;
  logic [23:0] goal_q [3];
  logic [23:0] goal_d [3];
  logic [1:0]  dir_q [3];
  logic [1:0]  dir_d [3];
  logic [2:0]  en_q, en_d;
  logic [7:0]  still_q [3];
  logic [7:0]  still_d [3];
  logic [2:0]  lenc_q, lenc_d;
  logic [1:0]  ax_q, ax_d;
  logic        cmdst_q, cmdst_d, donest_q, donest_d;
  logic [1:0]  cmdk_q, cmdk_d;
  logic        cmdv_q, cmdv_d;
  tick_t       tk_q, tk_d;
  res_t        out_q, out_d;
  logic        ov_q, ov_d;
  logic        can_emit;
  logic        emit;
  logic [1:0]  m0;
  logic [24:0] diff, mag;
  logic [24:0] np;
  logic        cnt_hit;

  assign can_emit = ~ov_q | res_take_i;
  assign res_valid_o = ov_q;
  assign res_o = out_q;

  // Encoder position step for the current axis, one bit wider so that it can be saturated.
  always_comb begin
    np = {pos_q[ax_q][23], pos_q[ax_q]};
    if (dir_q[ax_q] == DIR_REV) np = np - {9'd0, step_i};
    else if (dir_q[ax_q] == DIR_FWD) np = np + {9'd0, step_i};
    cnt_hit = lenc_q[ax_q] ^ tk_q.enc[ax_q];
  end

  always_comb begin
    logic [2:0] em;
    logic [7:0] sinc;
    logic       any_left;
    st_d = st_q; mode_d = mode_q; known_d = known_q; en_d = en_q;
    lenc_d = lenc_q; ax_d = ax_q; cmdst_d = cmdst_q; donest_d = donest_q;
    cmdk_d = cmdk_q; cmdv_d = cmdv_q; tk_d = tk_q; ov_d = ov_q & ~res_take_i;
    out_d = out_q; emit = 1'b0; q_pop_o = 1'b0; m0 = mode_q;
    diff = '0; mag = '0; em = '0; sinc = '0; any_left = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos_d[i] = pos_q[i]; goal_d[i] = goal_q[i]; dir_d[i] = dir_q[i];
      still_d[i] = still_q[i];
    end
    out_d.kind = KIND_DRIVE;
    out_d.command = OP_NONE; out_d.pos = '0; out_d.known = 1'b0;
    out_d.status = '0; out_d.enable = '0;
    out_d.dir_a = DIR_NONE; out_d.dir_b = DIR_NONE; out_d.dir_c = DIR_NONE;
    out_d.last = 1'b0;
    if (!can_emit) out_d = out_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          tk_d = tick_i;
          if (fault_i) m0 = MODE_ERROR;
          else if (mode_q == MODE_ERROR) m0 = MODE_IDLE;
          mode_d = m0;
          cmdv_d = 1'b0; cmdst_d = 1'b0;
          case (tick_i.op)
            OP_HOME: begin
              cmdv_d = 1'b1; cmdst_d = 1'b1;
              cmdk_d = (m0 != MODE_ERROR) ? KIND_ACK : KIND_NACK;
              if (m0 != MODE_ERROR) mode_d = MODE_HOMING;
            end
            OP_CANCEL: begin
              cmdv_d = 1'b1; cmdst_d = 1'b1;
              cmdk_d = (m0 != MODE_ERROR) ? KIND_ACK : KIND_NACK;
              if (m0 != MODE_ERROR) mode_d = MODE_IDLE;
            end
            OP_MOVE: begin
              cmdv_d = 1'b1; cmdk_d = KIND_NACK;
              if (known_q) begin
                cmdst_d = 1'b1;
                if (m0 != MODE_ERROR && tick_i.goal_ok) begin
                  cmdk_d = KIND_ACK; mode_d = MODE_MOVING;
                  goal_d[0] = tick_i.goals[23:0];
                  goal_d[1] = tick_i.goals[47:24];
                  goal_d[2] = tick_i.goals[71:48];
                end
              end
            end
            OP_STATUS: cmdst_d = 1'b1;
            default: ;
          endcase
          st_d = ST_CMD;
        end
      end
      ST_CMD: begin
        if (can_emit) begin
          if (cmdv_q) begin
            emit = 1'b1; out_d.kind = cmdk_q; out_d.command = tk_q.op;
            cmdv_d = 1'b0;
          end else if (cmdst_q) begin
            emit = 1'b1; out_d.kind = KIND_STATUS;
            out_d.pos = {pos_q[2], pos_q[1], pos_q[0]}; out_d.known = known_q;
            out_d.status = {~tk_q.stops, mode_q};
            cmdst_d = 1'b0;
          end else begin
            // Mode step: homing or bang-bang move.
            donest_d = 1'b0;
            if (mode_q == MODE_HOMING) begin
              if (tk_q.stops == 3'd0) begin
                en_d = '0; mode_d = MODE_IDLE; known_d = 1'b1; donest_d = 1'b1;
                for (int i = 0; i < 3; i++) pos_d[i] = '0;
              end else begin
                en_d = tk_q.stops;
                for (int i = 0; i < 3; i++) dir_d[i] = DIR_REV;
              end
              st_d = ST_CST;
            end else if (mode_q == MODE_MOVING) begin
              ax_d = ax_q + 2'd1;
              diff = {goal_q[ax_q][23], goal_q[ax_q]} - {pos_q[ax_q][23], pos_q[ax_q]};
              mag = diff[24] ? -diff : diff;
              if (mag > {9'd0, tol_i}) begin
                if (!diff[24] && diff != '0) begin
                  dir_d[ax_q] = DIR_FWD; en_d[ax_q] = 1'b1;
                end else begin
                  dir_d[ax_q] = DIR_REV; en_d[ax_q] = tk_q.stops[ax_q];
                end
              end else begin
                dir_d[ax_q] = DIR_NONE; en_d[ax_q] = 1'b0;
              end
              if (ax_q == 2'd2) begin
                ax_d = '0; st_d = ST_CST;
                em = en_q; em[2] = en_d[2];
                if (em == 3'd0) begin
                  mode_d = MODE_IDLE; donest_d = 1'b1;
                end
              end
            end else begin
              en_d = '0; st_d = ST_CST;
            end
          end
        end
      end
      ST_CST: begin
        if (can_emit) begin
          if (donest_q) begin
            emit = 1'b1; out_d.kind = KIND_STATUS;
            out_d.pos = {pos_q[2], pos_q[1], pos_q[0]}; out_d.known = known_q;
            out_d.status = {~tk_q.stops, mode_q};
            donest_d = 1'b0;
          end else begin
            st_d = ST_DRV;
          end
        end
      end
      ST_DRV: begin
        if (can_emit) begin
          emit = 1'b1; out_d.kind = KIND_DRIVE; out_d.enable = en_q;
          out_d.dir_a = dir_q[0]; out_d.dir_b = dir_q[1]; out_d.dir_c = dir_q[2];
          ax_d = '0;
          if (mode_q == MODE_MOVING) begin
            for (int i = 0; i < 3; i++)
              if (still_q[i] != 8'hFF) still_d[i] = still_q[i] + 8'd1;
            // Last if no axis will count an edge.
            for (int i = 0; i < 3; i++) begin
              sinc = (still_q[i] != 8'hFF) ? still_q[i] + 8'd1 : still_q[i];
              if ((lenc_q[i] ^ tk_q.enc[i]) && sinc > noise_i) any_left = 1'b1;
            end
            out_d.last = ~any_left;
            st_d = ST_ENC;
          end else begin
            for (int i = 0; i < 3; i++) still_d[i] = '0;
            out_d.last = 1'b1;
            st_d = ST_IDLE;
          end
        end
      end
      ST_ENC: begin
        if (can_emit) begin
          if (cnt_hit && still_q[ax_q] > noise_i) begin
            if (en_q[ax_q]) begin
              if (np[24] != np[23]) pos_d[ax_q] = np[24] ? 24'h800000 : 24'h7FFFFF;
              else pos_d[ax_q] = np[23:0];
            end
            emit = 1'b1; out_d.kind = KIND_STATUS;
            out_d.known = known_q; out_d.status = {~tk_q.stops, mode_q};
            out_d.pos = {pos_q[2], pos_q[1], pos_q[0]};
            case (ax_q)
              2'd0: out_d.pos[23:0] = pos_d[0];
              2'd1: out_d.pos[47:24] = pos_d[1];
              default: out_d.pos[71:48] = pos_d[2];
            endcase
            for (int i = 0; i < 3; i++)
              if (i > ax_q && (lenc_q[i] ^ tk_q.enc[i]) && still_q[i] > noise_i)
                any_left = 1'b1;
            out_d.last = ~any_left;
          end
          if (cnt_hit) still_d[ax_q] = '0;
          ax_d = ax_q + 2'd1;
          if (ax_q == 2'd2) begin
            ax_d = '0; lenc_d = tk_q.enc; st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (emit) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    tk_q <= tk_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; mode_q <= MODE_IDLE; known_q <= 1'b0; en_q <= '0;
      lenc_q <= '0; ax_q <= '0; cmdst_q <= 1'b0; donest_q <= 1'b0;
      cmdk_q <= KIND_DRIVE; cmdv_q <= 1'b0; ov_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0; goal_q[i] <= '0; dir_q[i] <= DIR_NONE; still_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; mode_q <= mode_d; known_q <= known_d; en_q <= en_d;
      lenc_q <= lenc_d; ax_q <= ax_d; cmdst_q <= cmdst_d; donest_q <= donest_d;
      cmdk_q <= cmdk_d; cmdv_q <= cmdv_d; ov_q <= ov_d;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= pos_d[i]; goal_q[i] <= goal_d[i];
        dir_q[i] <= dir_d[i]; still_q[i] <= still_d[i];
      end
    end
  end
endmodule

/* rtl/three_axis_bang_bang_motion_controller_top.sv */
// Each tick runs through a command step, an axis scan over the three axes while moving,
// the drive update and, while moving, an encoder scan over the three axes; the back end
// takes a new tick only once the last is done, and each result waits while out_stall_i is high.
// A two-entry queue decouples tick intake from the sequencing back end.
// Reset (rst_ni low, asynchronous): idle mode, positions zero and unknown,
// registers at 32, 640, 45 and 0.
module three_axis_bang_bang_motion_controller_top import tabb_pkg::*; #(
  parameter int PWM_FULL = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic signed [23:0] goal_a_i,
  input  logic signed [23:0] goal_b_i,
  input  logic signed [23:0] goal_c_i,
  input  logic        goal_invalid_i,
  input  logic        payload_ok_i,
  input  logic [2:0]  stop_bits_i,
  input  logic [2:0]  encoder_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  command_o,
  output logic signed [23:0] pos_a_o,
  output logic signed [23:0] pos_b_o,
  output logic signed [23:0] pos_c_o,
  output logic        pos_known_o,
  output logic [4:0]  status_word_o,
  output logic [2:0]  drive_enable_o,
  output logic [10:0] duty_a_o,
  output logic [10:0] duty_b_o,
  output logic [10:0] duty_c_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam logic [10:0] DUTY_FWD  = 11'(PWM_FULL);
  localparam logic [10:0] DUTY_IDLE = 11'(PWM_FULL / 2);

  logic [15:0] tol_q, step_q;
  logic [7:0]  noise_q;
  logic        fault_q;
  logic        q_valid, q_pop, res_valid;
  tick_t       head;
  res_t        res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd32; step_q <= 16'd640; noise_q <= 8'd45; fault_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TOL:   tol_q <= cfg_data_i;
        REG_STEP:  step_q <= cfg_data_i;
        REG_NOISE: noise_q <= cfg_data_i[7:0];
        REG_FAULT: fault_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tabb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .op_i(operation_i), .goals_i({goal_c_i, goal_b_i, goal_a_i}),
    .goal_invalid_i, .payload_ok_i, .stops_i(stop_bits_i), .enc_i(encoder_bits_i),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(head)
  );

  tabb_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .tick_i(head),
    .tol_i(tol_q), .step_i(step_q), .noise_i(noise_q), .fault_i(fault_q),
    .res_valid_o(res_valid), .res_take_i(res_valid & ~out_stall_i), .res_o(res)
  );

  function automatic logic [10:0] duty_of(input logic [1:0] d, input logic on);
    if (!on) return 11'd0;
    if (d == DIR_FWD) return DUTY_FWD;
    if (d == DIR_REV) return 11'd0;
    return DUTY_IDLE;
  endfunction

  // Output fields.
  assign out_valid_o = res_valid;
  assign kind_o = res.kind;
  assign command_o = res.command;
  assign pos_a_o = res.pos[23:0];
  assign pos_b_o = res.pos[47:24];
  assign pos_c_o = res.pos[71:48];
  assign pos_known_o = res.known;
  assign status_word_o = res.status;
  assign drive_enable_o = res.enable;
  assign duty_a_o = duty_of(res.dir_a, res.kind == KIND_DRIVE);
  assign duty_b_o = duty_of(res.dir_b, res.kind == KIND_DRIVE);
  assign duty_c_o = duty_of(res.dir_c, res.kind == KIND_DRIVE);
  assign last_o = res.last;
endmodule

/* rtl/tabb_checker.sv */
// Port-level checker for the motion controller, with its bind.
`include "three_axis_bang_bang_motion_controller_top_assert.svh"
module tabb_checker import tabb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [2:0] command_o,
  input logic [2:0] drive_enable_o,
  input logic       last_o
);
  `TABB_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o))
  `TABB_ASSERT_IMP(a_last_drive, clk_i, rst_ni, out_valid_o && last_o && kind_o != KIND_DRIVE, kind_o == KIND_STATUS)
  `TABB_ASSERT_IMP(a_cmd_zero, clk_i, rst_ni, out_valid_o && (kind_o == KIND_DRIVE || kind_o == KIND_STATUS), command_o == OP_NONE)
  `TABB_ASSERT_IMP(a_en_zero, clk_i, rst_ni, out_valid_o && kind_o != KIND_DRIVE, drive_enable_o == 3'd0)
endmodule

bind three_axis_bang_bang_motion_controller_top tabb_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .kind_o, .command_o,
  .drive_enable_o, .last_o
);

/* bench/three_axis_bang_bang_motion_controller_checker.sv */
// Checker for the motion controller: predicts every tick's results and compares them.
`timescale 1ns / 100ps
module three_axis_bang_bang_motion_controller_checker import tabb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         operation_i,
  input  logic signed [23:0] goal_a_i,
  input  logic signed [23:0] goal_b_i,
  input  logic signed [23:0] goal_c_i,
  input  logic               goal_invalid_i,
  input  logic               payload_ok_i,
  input  logic [2:0]         stop_bits_i,
  input  logic [2:0]         encoder_bits_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         command_i,
  input  logic signed [23:0] pos_a_i,
  input  logic signed [23:0] pos_b_i,
  input  logic signed [23:0] pos_c_i,
  input  logic               pos_known_i,
  input  logic [4:0]         status_word_i,
  input  logic [2:0]         drive_enable_i,
  input  logic [10:0]        duty_a_i,
  input  logic [10:0]        duty_b_i,
  input  logic [10:0]        duty_c_i,
  input  logic               last_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  localparam int PWM_FULL = 1024;
  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         command;
    logic signed [23:0] pa;
    logic signed [23:0] pb;
    logic signed [23:0] pc;
    logic               known;
    logic [4:0]         status;
    logic [2:0]         enable;
    logic [10:0]        da;
    logic [10:0]        db;
    logic [10:0]        dc;
    logic               last;
  } motion_res_t;

  motion_res_t expected_q[$];
  motion_res_t tick_q[$];

  // register copies
  int unsigned tol, step, noise;
  logic        fault;
  // controller state copy
  logic [1:0]  mode;
  int          pos[3];
  int          goal[3];
  logic        known;
  logic [1:0]  dir[3];
  logic [2:0]  en_mask;
  int unsigned still[3];
  logic [2:0]  last_enc;
  logic [2:0]  stops;

  function automatic logic [10:0] duty_for(logic [1:0] d);
    if (d == DIR_FWD) return PWM_FULL[10:0];
    else if (d == DIR_REV) return 11'd0;
    return 11'(PWM_FULL / 2);
  endfunction

  function void add_result(logic [1:0] kind, logic [2:0] cmd);
    motion_res_t r;
    r = '0;
    r.kind = kind;
    if (kind == KIND_ACK || kind == KIND_NACK) r.command = cmd;
    if (kind == KIND_STATUS) begin
      r.pa = pos[0][23:0];
      r.pb = pos[1][23:0];
      r.pc = pos[2][23:0];
      r.known = known;
      r.status = {~stops, mode};
    end
    if (kind == KIND_DRIVE) begin
      r.enable = en_mask;
      r.da = duty_for(dir[0]);
      r.db = duty_for(dir[1]);
      r.dc = duty_for(dir[2]);
    end
    if (tick_q.size() < 8) tick_q.push_back(r);
  endfunction

  // one control tick: command, drive, encoder
  function void predict_tick();
    logic [2:0] op, enc, changed;
    int diff, mag, p;
    op = operation_i;
    enc = encoder_bits_i;
    tick_q = {};
    if (fault) mode = MODE_ERROR;
    else if (mode == MODE_ERROR) mode = MODE_IDLE;
    stops = stop_bits_i;

    case (op)
      OP_HOME: begin
        if (mode != MODE_ERROR) begin
          mode = MODE_HOMING;
          add_result(KIND_ACK, op);
        end else add_result(KIND_NACK, op);
        add_result(KIND_STATUS, OP_NONE);
      end
      OP_MOVE: begin
        if (!known) add_result(KIND_NACK, op);
        else begin
          if (mode != MODE_ERROR && payload_ok_i && !goal_invalid_i) begin
            goal[0] = int'(goal_a_i);
            goal[1] = int'(goal_b_i);
            goal[2] = int'(goal_c_i);
            mode = MODE_MOVING;
            add_result(KIND_ACK, op);
          end else add_result(KIND_NACK, op);
          add_result(KIND_STATUS, OP_NONE);
        end
      end
      OP_CANCEL: begin
        if (mode != MODE_ERROR) begin
          mode = MODE_IDLE;
          add_result(KIND_ACK, op);
        end else add_result(KIND_NACK, op);
        add_result(KIND_STATUS, OP_NONE);
      end
      OP_STATUS: add_result(KIND_STATUS, OP_NONE);
      default: ;
    endcase

    // drive
    if (mode == MODE_HOMING) begin
      if (stops == 3'b000) begin
        en_mask = '0;
        mode = MODE_IDLE;
        for (int i = 0; i < 3; i++) pos[i] = 0;
        known = 1'b1;
        add_result(KIND_STATUS, OP_NONE);
      end else begin
        en_mask = stops;
        for (int i = 0; i < 3; i++) dir[i] = DIR_REV;
      end
    end else if (mode == MODE_MOVING) begin
      for (int i = 0; i < 3; i++) begin
        diff = goal[i] - pos[i];
        mag = diff < 0 ? -diff : diff;
        if (mag > int'(tol)) begin
          if (diff > 0) begin
            dir[i] = DIR_FWD;
            en_mask[i] = 1'b1;
          end else begin
            dir[i] = DIR_REV;
            en_mask[i] = stops[i];
          end
        end else begin
          en_mask[i] = 1'b0;
          dir[i] = DIR_NONE;
        end
      end
      if (en_mask == '0) begin
        mode = MODE_IDLE;
        add_result(KIND_STATUS, OP_NONE);
      end
    end else en_mask = '0;
    add_result(KIND_DRIVE, OP_NONE);

    // debounced encoder edges while moving
    if (mode == MODE_MOVING) begin
      changed = last_enc ^ enc;
      for (int i = 0; i < 3; i++) if (still[i] < 255) still[i]++;
      for (int i = 0; i < 3; i++) begin
        if (changed[i]) begin
          if (still[i] > noise) begin
            if (en_mask[i]) begin
              p = pos[i];
              if (dir[i] == DIR_REV) p -= int'(step);
              else if (dir[i] == DIR_FWD) p += int'(step);
              if (p > POS_MAX) p = POS_MAX;
              if (p < POS_MIN) p = POS_MIN;
              pos[i] = p;
            end
            add_result(KIND_STATUS, OP_NONE);
          end
          still[i] = 0;
        end
      end
      last_enc = enc;
    end else for (int i = 0; i < 3; i++) still[i] = 0;

    tick_q[tick_q.size() - 1].last = 1'b1;
    foreach (tick_q[k]) expected_q.push_back(tick_q[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motion_res_t got, want;
    if (!rst_ni) begin
      tol = 32; step = 640; noise = 45; fault = 1'b0;
      mode = MODE_IDLE; known = 1'b0; en_mask = '0; last_enc = '0; stops = '0;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0; goal[i] = 0; dir[i] = DIR_NONE; still[i] = 0;
      end
      expected_q = {};
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // result channel
      if (out_valid_i && !out_stall_i) begin
        got = '{kind_i, command_i, pos_a_i, pos_b_i, pos_c_i, pos_known_i, status_word_i,
                drive_enable_i, duty_a_i, duty_b_i, duty_c_i, last_i};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %h got %h", want, got);
          end
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TOL:   tol = {16'd0, cfg_data_i};
          REG_STEP:  step = {16'd0, cfg_data_i};
          REG_NOISE: noise = {24'd0, cfg_data_i[7:0]};
          REG_FAULT: fault = cfg_data_i[0];
          default: ;
        endcase
      end
      // tick channel
      if (in_valid_i && !in_stall_i) predict_tick();
      pending_o = expected_q.size();
    end
  end
endmodule

/* bench/three_axis_bang_bang_motion_controller_top_tb.sv */
// Testbench top for the motion controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module three_axis_bang_bang_motion_controller_top_tb import tabb_pkg::*;;
  localparam int LIMIT = 500000;

  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic [2:0]         operation;
  logic signed [23:0] goal_a, goal_b, goal_c;
  logic               goal_invalid, payload_ok;
  logic [2:0]         stop_bits, encoder_bits;
  logic               out_valid, out_stall;
  logic [1:0]         kind;
  logic [2:0]         command;
  logic signed [23:0] pos_a, pos_b, pos_c;
  logic               pos_known;
  logic [4:0]         status_word;
  logic [2:0]         drive_enable;
  logic [10:0]        duty_a, duty_b, duty_c;
  logic               last;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, pending;
  int                 cycles;
  logic [2:0]         enc_level;
  bit                 hold_go, hold_done, no_gap, quiet;

  three_axis_bang_bang_motion_controller_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .goal_a_i(goal_a), .goal_b_i(goal_b), .goal_c_i(goal_c),
    .goal_invalid_i(goal_invalid), .payload_ok_i(payload_ok),
    .stop_bits_i(stop_bits), .encoder_bits_i(encoder_bits),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .command_o(command), .pos_a_o(pos_a), .pos_b_o(pos_b), .pos_c_o(pos_c),
    .pos_known_o(pos_known), .status_word_o(status_word), .drive_enable_o(drive_enable),
    .duty_a_o(duty_a), .duty_b_o(duty_b), .duty_c_o(duty_c), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  three_axis_bang_bang_motion_controller_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .goal_a_i(goal_a), .goal_b_i(goal_b), .goal_c_i(goal_c),
    .goal_invalid_i(goal_invalid), .payload_ok_i(payload_ok),
    .stop_bits_i(stop_bits), .encoder_bits_i(encoder_bits),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .command_i(command), .pos_a_i(pos_a), .pos_b_i(pos_b), .pos_c_i(pos_c),
    .pos_known_i(pos_known), .status_word_i(status_word), .drive_enable_i(drive_enable),
    .duty_a_i(duty_a), .duty_b_i(duty_b), .duty_c_i(duty_c), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) cycles <= cycles + 1;
  initial begin
    wait (cycles >= LIMIT);
    $display("FAIL three_axis_bang_bang_motion_controller_top");
    $finish;
  end

  // result side back-pressure: random runs, one long hold on request
  initial begin
    int run_left;
    bit run_stall;
    run_left = 0;
    run_stall = 0;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = !quiet && $urandom_range(0, 3) == 0;
          if (run_stall)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
          else run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  // offer one tick, with a random gap before it
  task automatic send_tick(logic [2:0] op, logic signed [23:0] ga, logic signed [23:0] gb,
                           logic signed [23:0] gc, logic inv, logic pok, logic [2:0] stops,
                           logic [2:0] enc);
    int gap, r;
    gap = 0;
    if (!no_gap) begin
      r = $urandom_range(0, 19);
      if (r >= 18) gap = $urandom_range(10, 40);
      else if (r >= 12) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    goal_a <= ga;
    goal_b <= gb;
    goal_c <= gc;
    goal_invalid <= inv;
    payload_ok <= pok;
    stop_bits <= stops;
    encoder_bits <= enc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // all expected results in and the back end drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random tick, weighted towards homing and moves that finish
  task automatic random_tick();
    int r;
    logic [2:0] op, stops;
    logic signed [23:0] ga, gb, gc;
    logic inv, pok;
    r = $urandom_range(0, 99);
    ga = 24'($urandom);
    gb = 24'($urandom);
    gc = 24'($urandom);
    inv = $urandom_range(0, 14) == 0;
    pok = $urandom_range(0, 14) != 0;
    if (r < 6) op = OP_HOME;
    else if (r < 20) begin
      op = OP_MOVE;
      ga = 24'(int'($urandom_range(0, 8000)) - 4000);
      gb = 24'(int'($urandom_range(0, 8000)) - 4000);
      gc = 24'(int'($urandom_range(0, 8000)) - 4000);
    end else if (r < 23) op = OP_MOVE;
    else if (r < 27) op = OP_CANCEL;
    else if (r < 32) op = OP_STATUS;
    else if (r < 34) op = 3'($urandom_range(5, 7));
    else op = OP_NONE;
    r = $urandom_range(0, 9);
    if (r < 2) stops = 3'b000;
    else if (r < 3) stops = 3'($urandom_range(0, 7));
    else stops = 3'b111;
    if ($urandom_range(0, 1)) enc_level = enc_level ^ 3'($urandom_range(1, 7));
    send_tick(op, ga, gb, gc, inv, pok, stops, enc_level);
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    enc_level = '0;
    hold_go = 0;
    hold_done = 0;
    no_gap = 0;
    quiet = 0;
    in_valid <= 1'b0;
    operation <= OP_NONE;
    goal_a <= '0;
    goal_b <= '0;
    goal_c <= '0;
    goal_invalid <= 1'b0;
    payload_ok <= 1'b1;
    stop_bits <= 3'b111;
    encoder_bits <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TOL;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: unknown positions, homing, refused and accepted moves, unused codes
    send_tick(OP_STATUS, 0, 0, 0, 0, 1, 3'b111, 3'b000);
    send_tick(OP_MOVE, 100, 100, 100, 0, 1, 3'b111, 3'b000);
    send_tick(OP_CANCEL, 0, 0, 0, 0, 1, 3'b010, 3'b000);
    send_tick(3'd7, -1, -1, -1, 1, 0, 3'b111, 3'b111);
    send_tick(OP_HOME, 0, 0, 0, 0, 1, 3'b111, 3'b000);
    send_tick(OP_NONE, 0, 0, 0, 0, 1, 3'b011, 3'b000);
    send_tick(OP_NONE, 0, 0, 0, 0, 1, 3'b000, 3'b000);
    send_tick(OP_MOVE, 5000, 5000, 5000, 1, 1, 3'b111, 3'b000);
    send_tick(OP_MOVE, 5000, 5000, 5000, 0, 0, 3'b111, 3'b000);
    send_tick(OP_MOVE, 24'sd8388607, -24'sd8388608, 24'sd20, 0, 1, 3'b111, 3'b000);
    send_tick(OP_NONE, 0, 0, 0, 0, 1, 3'b101, 3'b111);
    send_tick(OP_STATUS, 0, 0, 0, 0, 1, 3'b111, 3'b000);
    send_tick(3'd5, 0, 0, 0, 0, 1, 3'b111, 3'b101);
    send_tick(3'd6, 0, 0, 0, 0, 1, 3'b111, 3'b010);
    send_tick(OP_CANCEL, 0, 0, 0, 0, 1, 3'b111, 3'b000);
    wait_idle();

    // fast encoder, narrow band; no result stalls for a while
    write_reg(REG_TOL, 16'd64);
    write_reg(REG_STEP, 16'd256);
    write_reg(REG_NOISE, 16'd0);
    write_reg(REG_FAULT, 16'd0);
    quiet = 1;
    repeat (25) random_tick();
    quiet = 0;
    repeat (35) random_tick();

    // receiver holds off while ticks keep coming
    hold_go = 1;
    no_gap = 1;
    repeat (20) random_tick();
    no_gap = 0;
    wait_idle();

    // upper extremes
    write_reg(REG_TOL, 16'hFFFF);
    write_reg(REG_STEP, 16'hFFFF);
    write_reg(REG_NOISE, 16'd255);
    repeat (20) random_tick();
    wait_idle();

    // lower extremes, then a driver fault
    write_reg(REG_TOL, 16'd0);
    write_reg(REG_STEP, 16'd0);
    write_reg(REG_NOISE, 16'd0);
    repeat (10) random_tick();
    wait_idle();
    write_reg(REG_FAULT, 16'd1);
    send_tick(OP_HOME, 0, 0, 0, 0, 1, 3'b111, enc_level);
    send_tick(OP_MOVE, 10, 10, 10, 0, 1, 3'b111, enc_level);
    send_tick(OP_CANCEL, 0, 0, 0, 0, 1, 3'b111, enc_level);
    repeat (10) random_tick();
    wait_idle();
    write_reg(REG_FAULT, 16'd0);

    // big steps towards far goals to reach the position limits
    write_reg(REG_TOL, 16'd32);
    write_reg(REG_STEP, 16'hFFFF);
    write_reg(REG_NOISE, 16'd1);
    repeat (30) random_tick();
    wait_idle();

    if (fail_count == 0) begin
      $display("PASS three_axis_bang_bang_motion_controller_top");
    end else begin
      $display("FAIL three_axis_bang_bang_motion_controller_top");
    end
    $finish;
  end
endmodule
